### rtl/double_hash_table_assert.svh
// Assertion macros for the hash table block.
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define DHT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define DHT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### rtl/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants and types of the double hashing table.
// ----------------------------------------------------------------------------
package dht_pkg;
    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BITS    = 14;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_NOTFOUND = 2'd1;
    localparam logic [1:0] RES_FULL     = 2'd2;

    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_DELETED  = 2'd2;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [12:0] divisor;
    } dht_div_req_t;

    typedef struct packed {
        logic        done;
        logic [12:0] rem;
    } dht_div_rsp_t;
endpackage

### rtl/double_hash_table.sv
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressing hash table with double hashing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one request (insert, search, remove) per transfer.
//   m_axis_* returns one result per request, in order.
//   table_size_we/table_size write the modulus m (saturated to [2, depth]);
//   write only while idle.
// Sequence: two serial remainders (key mod m, key mod m-1), then one or
//   more probes (read, compare, write/step); the probe count depends on
//   data.
//   One request is in flight at a time; the next is accepted once its
//   result sits in the output register.
// Reset: a clearing pass walks every slot of the status memory, one slot a
//   cycle; no request is accepted until it ends.
// Stall: a result waits in the output register while m_axis_tready is low;
//   a new request may be accepted and worked on meanwhile, but its result
//   waits for the register to drain.
// Step arithmetic: the probe index advances by b mod m with a compare and
//   subtract, since both are below m.
// ----------------------------------------------------------------------------
`include "double_hash_table_assert.svh"

module double_hash_table #(
    parameter int TABLE_DEPTH = dht_pkg::TABLE_DEPTH,
    parameter int KEY_BITS    = dht_pkg::KEY_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         table_size_we,
    input  logic [7:0]   table_size,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key, name_id, age, weight_bits, height_bits (from bit 0), zero padded
    input  logic [((KEY_BITS + 143) / 8) * 8 - 1:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot, found_name, found_age, found_weight, found_height (from bit 0)
    output logic [143:0] m_axis_tdata,
    // result_code
    output logic [1:0]   m_axis_tuser
);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int MW  = $clog2(TABLE_DEPTH + 1);
    localparam int RW  = 136;
    localparam int DEN = 13;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MODA, S_MODB, S_READ, S_WAIT, S_CHECK, S_OUT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_reg;
    logic [7:0]    tsize_reg;
    logic [1:0]    func_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [63:0]   name_reg;
    logic [71:0]   rec_reg;
    logic [MW-1:0] m_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] step_reg;
    logic [MW-1:0] cnt_reg;
    logic          ovalid_reg;
    logic [1:0]    ocode_reg;
    logic [AW-1:0] oslot_reg;
    logic [RW-1:0] orec_reg;
    logic [1:0]    rcode_reg;
    logic [AW-1:0] rslot_reg;
    logic [RW-1:0] rrec_reg;

    // memories
    logic [1:0]    status_mem [TABLE_DEPTH];
    logic [KEY_BITS+RW-1:0] data_mem [TABLE_DEPTH];
    logic [1:0]    st_rd;
    logic [KEY_BITS+RW-1:0] data_rd;
    logic          st_we;
    logic [AW-1:0] st_wa;
    logic [1:0]    st_wd;
    logic          d_we;

    // m saturated
    logic [MW-1:0] m_sat;
    always_comb
    begin
        if (tsize_reg < 8'd2)
            m_sat = MW'(2);
        else if (32'(tsize_reg) > TABLE_DEPTH)
            m_sat = MW'(TABLE_DEPTH);
        else
            m_sat = MW'(tsize_reg);
    end

    dht_pkg::dht_div_req_t div_req;
    dht_pkg::dht_div_rsp_t div_rsp;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = 32'(key_reg);
        div_req.divisor  = DEN'(m_reg);
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'(s_axis_tdata[KEY_BITS-1:0]);
            div_req.divisor  = DEN'(m_sat);
        end
        else if (state_reg == S_MODA && div_rsp.done)
        begin
            div_req.start   = 1'b1;
            div_req.divisor = DEN'(m_reg - 1'b1);
        end
    end

    dht_mod #(.NUM_BITS(32), .DEN_BITS(DEN)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_req.start),
        .dividend (div_req.dividend),
        .divisor  (div_req.divisor),
        .done     (div_rsp.done),
        .rem      (div_rsp.rem)
    );

    // next probe: idx + step mod m, both below m
    logic [AW:0] nsum;
    logic [AW-1:0] nidx;
    always_comb
    begin
        nsum = {1'b0, idx_reg} + {1'b0, step_reg};
        if (32'(nsum) >= 32'(m_reg))
            nidx = AW'(32'(nsum) - 32'(m_reg));
        else
            nidx = nsum[AW-1:0];
    end

    // step = (1 + key mod (m-1)) mod m ; rem is below m-1, so step_raw never reaches m and the map to 0 never fires
    logic [AW:0] step_raw;
    always_comb
    begin
        step_raw = (AW+1)'(div_rsp.rem) + 1'b1;
    end

    logic hit;
    logic [KEY_BITS-1:0] rd_key;
    always_comb
    begin
        rd_key = data_rd[KEY_BITS+RW-1:RW];
        hit = (st_rd == dht_pkg::ST_OCCUPIED) && (rd_key == key_reg)
            && (data_rd[RW-1:RW-64] == name_reg);
    end

    always_comb
    begin
        st_we = 1'b0;
        st_wa = idx_reg;
        st_wd = dht_pkg::ST_OCCUPIED;
        d_we  = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            st_we = 1'b1;
            st_wa = clr_reg;
            st_wd = dht_pkg::ST_EMPTY;
        end
        else if (state_reg == S_CHECK)
        begin
            if (func_reg == dht_pkg::FUNC_INSERT && st_rd != dht_pkg::ST_OCCUPIED)
            begin
                st_we = 1'b1;
                d_we  = 1'b1;
            end
            else if (func_reg == dht_pkg::FUNC_REMOVE && hit)
            begin
                st_we = 1'b1;
                st_wd = dht_pkg::ST_DELETED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            status_mem[st_wa] <= st_wd;
        if (d_we)
            data_mem[idx_reg] <= {key_reg, name_reg, rec_reg};
        st_rd   <= status_mem[idx_reg];
        data_rd <= data_mem[idx_reg];
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            tsize_reg  <= 8'd128;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (table_size_we)
                tsize_reg <= table_size;
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == TABLE_DEPTH - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        func_reg  <= s_axis_tuser;
                        key_reg   <= s_axis_tdata[KEY_BITS-1:0];
                        name_reg  <= s_axis_tdata[KEY_BITS+63:KEY_BITS];
                        rec_reg   <= {s_axis_tdata[KEY_BITS+71:KEY_BITS+64],
                                      s_axis_tdata[KEY_BITS+103:KEY_BITS+72],
                                      s_axis_tdata[KEY_BITS+135:KEY_BITS+104]};
                        m_reg     <= m_sat;
                        cnt_reg   <= '0;
                        rrec_reg  <= '0;
                        rslot_reg <= '0;
                        rcode_reg <= dht_pkg::RES_NOTFOUND;
                        if (s_axis_tuser == dht_pkg::FUNC_UNUSED)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_MODA;
                    end
                end
                S_MODA:
                begin
                    if (div_rsp.done)
                    begin
                        idx_reg   <= AW'(div_rsp.rem);
                        state_reg <= S_MODB;
                    end
                end
                S_MODB:
                begin
                    if (div_rsp.done)
                    begin
                        if (32'(step_raw) >= 32'(m_reg))
                            step_reg <= '0;
                        else
                            step_reg <= step_raw[AW-1:0];
                        if (func_reg == dht_pkg::FUNC_INSERT)
                            rcode_reg <= dht_pkg::RES_FULL;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_WAIT;
                S_WAIT:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    idx_reg <= nidx;
                    state_reg <= S_READ;
                    if (func_reg == dht_pkg::FUNC_INSERT)
                    begin
                        if (st_rd != dht_pkg::ST_OCCUPIED)
                        begin
                            rcode_reg <= dht_pkg::RES_OK;
                            rslot_reg <= idx_reg;
                            state_reg <= S_OUT;
                        end
                    end
                    else if (hit)
                    begin
                        rcode_reg <= dht_pkg::RES_OK;
                        rslot_reg <= idx_reg;
                        if (func_reg == dht_pkg::FUNC_SEARCH)
                            rrec_reg <= data_rd[RW-1:0];
                        state_reg <= S_OUT;
                    end
                    else if (st_rd == dht_pkg::ST_EMPTY)
                        state_reg <= S_OUT;
                    if (cnt_reg + 1'b1 == m_reg)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ovalid_reg || m_axis_tready))
        begin
            ocode_reg <= rcode_reg;
            oslot_reg <= rslot_reg;
            orec_reg  <= rrec_reg;
        end
    end

    logic [6:0] slot7;
    assign slot7 = 7'(oslot_reg);

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = ocode_reg;
    // orec_reg: name [135:72], age [71:64], weight [63:32], height [31:0]
    assign m_axis_tdata  = {1'b0, orec_reg[31:0], orec_reg[63:32], orec_reg[71:64],
                            orec_reg[135:72], slot7};

    // unused bits of the input word
    logic unused_bits;
    assign unused_bits = ^(s_axis_tdata >> (KEY_BITS + 136));

    `DHT_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == S_IDLE,
        "ready outside idle")
    `DHT_ASSERT_IMP(a_probe_bound, clk, rst_n, state_reg == S_CHECK, cnt_reg < m_reg,
        "probe count beyond m")
    `DHT_ASSERT_IMP(a_idx_bound, clk, rst_n, state_reg == S_READ, 32'(idx_reg) < 32'(m_reg),
        "probe index beyond m")
    `DHT_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

### rtl/dht_mod.sv
// ----------------------------------------------------------------------------
// dht_mod
// Serial restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dht_mod #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic                done,
    output logic [DEN_BITS-1:0] rem
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] num_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS:0]   rem_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        trial = {rem_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
                rem_reg <= trial - {1'b0, den_reg};
            else
                rem_reg <= trial;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[DEN_BITS-1:0];
endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double hashing table: drives insert, search,
// remove and unused-code requests with random gaps, mirrors the table in a scoreboard and
// compares every result field by field, over several table sizes.
// ----------------------------------------------------------------------------
class hash_table_scoreboard;
    logic [1:0]  st_q [128];
    logic [13:0] key_q [128];
    logic [63:0] name_q [128];
    logic [7:0]  age_q [128];
    logic [31:0] wt_q [128];
    logic [31:0] ht_q [128];
    logic [7:0]  size_reg;
    logic [1:0]  code_exp [$];
    logic [143:0] data_exp [$];
    int errors;

    function new();
        errors = 0;
        size_reg = 8'd128;
        foreach (st_q[i]) st_q[i] = dht_pkg::ST_EMPTY;
    endfunction

    function int modulus();
        int m;
        m = int'(size_reg);
        if (m < 2) m = 2;
        if (m > 128) m = 128;
        return m;
    endfunction

    function int probe_slot(int key, int m, int i);
        return (key % m + i * (1 + key % (m - 1))) % m;
    endfunction

    function int find_slot(int key, logic [63:0] name, int m);
        int j;
        for (int i = 0; i < m; i++)
        begin
            j = probe_slot(key, m, i);
            if (st_q[j] == dht_pkg::ST_OCCUPIED && key_q[j] == key && name_q[j] == name)
                return j;
            if (st_q[j] == dht_pkg::ST_EMPTY)
                return -1;
        end
        return -1;
    endfunction

    // predict the result of one accepted request
    function void note_request(logic [1:0] func, logic [151:0] d);
        int m, j, key;
        logic [1:0] code;
        logic [6:0] slot;
        logic [135:0] rec;
        m = modulus();
        key = int'(d[13:0]);
        code = dht_pkg::RES_NOTFOUND;
        slot = '0;
        rec = '0;
        if (func == dht_pkg::FUNC_INSERT)
        begin
            code = dht_pkg::RES_FULL;
            for (int i = 0; i < m; i++)
            begin
                j = probe_slot(key, m, i);
                if (st_q[j] != dht_pkg::ST_OCCUPIED)
                begin
                    st_q[j] = dht_pkg::ST_OCCUPIED;
                    key_q[j] = d[13:0];
                    name_q[j] = d[77:14];
                    age_q[j] = d[85:78];
                    wt_q[j] = d[117:86];
                    ht_q[j] = d[149:118];
                    code = dht_pkg::RES_OK;
                    slot = 7'(j);
                    break;
                end
            end
        end
        else if (func == dht_pkg::FUNC_SEARCH || func == dht_pkg::FUNC_REMOVE)
        begin
            j = find_slot(key, d[77:14], m);
            if (j >= 0)
            begin
                code = dht_pkg::RES_OK;
                slot = 7'(j);
                if (func == dht_pkg::FUNC_SEARCH)
                    rec = {ht_q[j], wt_q[j], age_q[j], name_q[j]};
                else
                    st_q[j] = dht_pkg::ST_DELETED;
            end
        end
        code_exp.push_back(code);
        data_exp.push_back({1'b0, rec, slot});
    endfunction

    function void check_result(logic [1:0] code, logic [143:0] d);
        logic [143:0] e;
        if (code_exp.size() == 0)
        begin
            $error("unexpected result transfer");
            errors++;
            return;
        end
        e = data_exp.pop_front();
        if (code !== code_exp[0])
        begin
            $error("result_code exp %0d got %0d", code_exp[0], code);
            errors++;
        end
        void'(code_exp.pop_front());
        if (d[6:0] !== e[6:0])
        begin
            $error("slot exp %0d got %0d", e[6:0], d[6:0]);
            errors++;
        end
        if (d[70:7] !== e[70:7])
        begin
            $error("found_name exp %h got %h", e[70:7], d[70:7]);
            errors++;
        end
        if (d[78:71] !== e[78:71])
        begin
            $error("found_age exp %h got %h", e[78:71], d[78:71]);
            errors++;
        end
        if (d[110:79] !== e[110:79])
        begin
            $error("found_weight exp %h got %h", e[110:79], d[110:79]);
            errors++;
        end
        if (d[142:111] !== e[142:111])
        begin
            $error("found_height exp %h got %h", e[142:111], d[142:111]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic         clk = 0;
    logic         rst_n = 0;
    logic         table_size_we = 0;
    logic [7:0]   table_size = 8'd128;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [143:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    hash_table_scoreboard sb = new();
    bit   hold_off = 0;     // long receiver stall requested
    // recently inserted records, so searches and removes can hit
    logic [13:0] used_key [$];
    logic [63:0] used_name [$];

    always #1 clk = ~clk;

    double_hash_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .table_size_we(table_size_we), .table_size(table_size),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 150);
    endfunction

    // one request transfer, after a gap of the given length; tvalid stays up for a
    // back-to-back transfer and drops when a gap follows
    task send_req(logic [1:0] func, logic [13:0] key, logic [63:0] name,
                  logic [7:0] age, logic [31:0] wt, logic [31:0] ht, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {2'b00, ht, wt, age, name, key};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_request(func, {2'b00, ht, wt, age, name, key});
        if (func == dht_pkg::FUNC_INSERT)
        begin
            used_key.push_back(key);
            used_name.push_back(name);
            if (used_key.size() > 40)
            begin
                void'(used_key.pop_front());
                void'(used_name.pop_front());
            end
        end
    endtask

    task random_req(int gap);
        logic [1:0]  func;
        logic [13:0] key;
        logic [63:0] name;
        int k;
        func = 2'($urandom_range(0, 3));
        if (func == dht_pkg::FUNC_UNUSED && $urandom_range(0, 3) != 0)
            func = dht_pkg::FUNC_SEARCH;
        key = 14'($urandom);
        name = {$urandom, $urandom};
        if (func != dht_pkg::FUNC_INSERT && used_key.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            k = $urandom_range(0, used_key.size() - 1);
            key = used_key[k];
            name = used_name[k];
        end
        else if ($urandom_range(0, 3) == 0)
            key = 14'($urandom_range(0, 7));   // collide on purpose
        send_req(func, key, name, 8'($urandom), $urandom, $urandom, gap);
    endtask

    task wait_drain();
        s_axis_tvalid <= 0;
        while (sb.code_exp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task write_size(logic [7:0] v);
        table_size_we <= 1;
        table_size    <= v;
        sb.size_reg = v;
        @(posedge clk);
        table_size_we <= 0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int g;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            if (hold_off)
            begin
                m_axis_tready <= 0;
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0)
            begin
                m_axis_tready <= 0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1;
        end
    end

    initial
    begin
        int sizes [6];
        sizes = '{128, 2, 3, 255, 1, 17};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        // directed: field extremes, every operation, full table, bad func code
        write_size(8'd2);
        send_req(dht_pkg::FUNC_SEARCH, 14'd0, 64'd0, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_INSERT, 14'h3fff, '1, 8'hff, '1, '1, 0);
        send_req(dht_pkg::FUNC_INSERT, 14'd0, 64'd0, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_INSERT, 14'd5, 64'd1, 8'd1, 32'd1, 32'd1, 0);
        send_req(dht_pkg::FUNC_SEARCH, 14'h3fff, '1, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_SEARCH, 14'h3fff, 64'd0, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_REMOVE, 14'd0, 64'd0, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_REMOVE, 14'd0, 64'd0, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_SEARCH, 14'h3fff, '1, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_INSERT, 14'd9, 64'd2, 8'h5a, 32'h1234, 32'h5678, 0);
        send_req(dht_pkg::FUNC_UNUSED, 14'd9, 64'd2, 8'd0, 32'd0, 32'd0, 0);
        send_req(dht_pkg::FUNC_SEARCH, 14'd9, 64'd2, 8'd0, 32'd0, 32'd0, 0);
        // pause until all results are back, then clear the list of used records
        wait_drain();
        used_key.delete();
        used_name.delete();
        // random phases over several sizes
        for (int p = 0; p < 6; p++)
        begin
            wait_drain();
            write_size(8'(sizes[p]));
            if (p == 0) hold_off = 1;
            for (int n = 0; n < 300; n++)
                random_req((p == 1 || $urandom_range(0, 2) == 0) ? gap_len() : 0);
        end
        wait_drain();
        if (sb.errors == 0 && sb.code_exp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
